FILE: design/shbh_pkg.sv
// shared types, round constants and initial hash values for the sha-256 byte stream hasher
// no dependencies; used by shbh_round and sha256_byte_stream_hasher_top
package shbh_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] vars_t;
    typedef logic [15:0][31:0] sched_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LEN_ROOM_LAST = 6'd55;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd7;

    localparam word_t IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic vars_t iv_vars();
        vars_t r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = IV_TABLE[i];
        end
        return r;
    endfunction

endpackage

FILE: design/sha256_byte_stream_hasher_top.sv
// sha-256 hasher over a byte stream: block shift buffer, padding sequencer, shared round unit
// depends on shbh_pkg and shbh_round
//
// channel   dir  signals                         contents
// s_axis    in   s_tvalid s_tready s_tdata ...   data_byte; tuser has_byte; tlast is_last
// m_axis    out  m_tvalid m_tready m_tdata ...   digest_word, word_index; tlast last_word
//
// the 64th byte of a block starts a compression
// (64 rounds on the single round unit, then one chaining add)
// a last transaction adds padding, one or two compressions, then 8 output words
// s_tready is high only in the idle state; the output words wait on m_tready
// reset is asynchronous and loads the initial hash values
module sha256_byte_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tlast
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    shbh_pkg::sched_t buf_reg, buf_next;
    shbh_pkg::vars_t  vars_reg, vars_next, round_vars;
    shbh_pkg::vars_t  chain_reg, chain_next;
    shbh_pkg::word_t  w_new;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] count_reg, count_next;
    logic        pad_reg, pad_next;
    logic        first_reg, first_next;
    logic        len_ok_reg, len_ok_next;
    logic        last_pend_reg, last_pend_next;
    logic [7:0]  shift_byte;
    logic [519:0] shifted;
    logic        s_accept, m_accept;

    shbh_round u_round (
        .vars_in  (vars_reg),
        .window   (buf_reg),
        .k        (shbh_pkg::K_TABLE[rnd_reg]),
        .vars_out (round_vars),
        .w_new    (w_new)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_OUT);
    assign m_accept = m_tvalid && m_tready;
    assign m_tdata  = {5'b00000, idx_reg, chain_reg[idx_reg]};
    assign m_tlast  = (idx_reg == shbh_pkg::WORD_LAST);

    // data byte when idle; padding: marker, zero fill, then bit length msb first
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            shift_byte = s_tdata;
        end
        else if (first_reg)
        begin
            shift_byte = shbh_pkg::PAD_BYTE;
        end
        else if (len_ok_reg && (fill_reg >= shbh_pkg::LEN_START))
        begin
            shift_byte = count_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            shift_byte = 8'h00;
        end
    end

    assign shifted = {buf_reg, shift_byte};

    always_comb
    begin
        state_next     = state_reg;
        buf_next       = buf_reg;
        vars_next      = vars_reg;
        chain_next     = chain_reg;
        fill_next      = fill_reg;
        rnd_next       = rnd_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        pad_next       = pad_reg;
        first_next     = first_reg;
        len_ok_next    = len_ok_reg;
        last_pend_next = last_pend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser)
                    begin
                        buf_next   = shifted[511:0];
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 64'd8;
                    end
                    if (s_tuser && (fill_reg == shbh_pkg::FILL_LAST))
                    begin
                        last_pend_next = s_tlast;
                        vars_next      = chain_reg;
                        rnd_next       = '0;
                        state_next     = S_ROUND;
                    end
                    else if (s_tlast)
                    begin
                        pad_next    = 1'b1;
                        first_next  = 1'b1;
                        len_ok_next = 1'b0;
                        state_next  = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                buf_next  = shifted[511:0];
                fill_next = fill_reg + 6'd1;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    if (fill_reg <= shbh_pkg::LEN_ROOM_LAST)
                    begin
                        len_ok_next = 1'b1;
                    end
                end
                if (fill_reg == shbh_pkg::FILL_LAST)
                begin
                    vars_next  = chain_reg;
                    rnd_next   = '0;
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                vars_next = round_vars;
                buf_next  = {buf_reg[14:0], w_new};
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == shbh_pkg::ROUND_LAST)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                end
                if (pad_reg)
                begin
                    if (len_ok_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        len_ok_next = 1'b1;
                        state_next  = S_PAD;
                    end
                end
                else if (last_pend_reg)
                begin
                    last_pend_next = 1'b0;
                    pad_next       = 1'b1;
                    first_next     = 1'b1;
                    len_ok_next    = 1'b0;
                    state_next     = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (m_accept)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == shbh_pkg::WORD_LAST)
                    begin
                        chain_next     = shbh_pkg::iv_vars();
                        fill_next      = '0;
                        count_next     = '0;
                        pad_next       = 1'b0;
                        first_next     = 1'b0;
                        len_ok_next    = 1'b0;
                        last_pend_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chain_reg     <= shbh_pkg::iv_vars();
            fill_reg      <= '0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            pad_reg       <= 1'b0;
            first_reg     <= 1'b0;
            len_ok_reg    <= 1'b0;
            last_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            fill_reg      <= fill_next;
            rnd_reg       <= rnd_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            pad_reg       <= pad_next;
            first_reg     <= first_next;
            len_ok_reg    <= len_ok_next;
            last_pend_reg <= last_pend_next;
        end
    end

    // block buffer and working variables carry no reset
    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        vars_reg <= vars_next;
    end

endmodule

FILE: design/shbh_round.sv
// one sha-256 round with the matching message schedule step
// depends on shbh_pkg
module shbh_round (
    input  shbh_pkg::vars_t  vars_in,
    input  shbh_pkg::sched_t window,
    input  shbh_pkg::word_t  k,
    output shbh_pkg::vars_t  vars_out,
    output shbh_pkg::word_t  w_new
);

    shbh_pkg::word_t w, m1, m6, m14, s0, s1, bs0, bs1, ch, maj, t1, t2;

    // window[15] is the oldest word, window[0] the newest
    assign w   = window[15];
    assign m14 = window[14];
    assign m6  = window[6];
    assign m1  = window[1];

    assign s0 = {m14[6:0], m14[31:7]} ^ {m14[17:0], m14[31:18]} ^ (m14 >> 3);
    assign s1 = {m1[16:0], m1[31:17]} ^ {m1[18:0], m1[31:19]} ^ (m1 >> 10);
    assign w_new = s1 + m6 + s0 + w;

    assign bs1 = {vars_in[4][5:0], vars_in[4][31:6]} ^ {vars_in[4][10:0], vars_in[4][31:11]}
               ^ {vars_in[4][24:0], vars_in[4][31:25]};
    assign bs0 = {vars_in[0][1:0], vars_in[0][31:2]} ^ {vars_in[0][12:0], vars_in[0][31:13]}
               ^ {vars_in[0][21:0], vars_in[0][31:22]};
    assign ch  = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
    assign maj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2])
               ^ (vars_in[1] & vars_in[2]);
    assign t1  = vars_in[7] + bs1 + ch + k + w;
    assign t2  = bs0 + maj;

    always_comb
    begin
        vars_out[7] = vars_in[6];
        vars_out[6] = vars_in[5];
        vars_out[5] = vars_in[4];
        vars_out[4] = vars_in[3] + t1;
        vars_out[3] = vars_in[2];
        vars_out[2] = vars_in[1];
        vars_out[1] = vars_in[0];
        vars_out[0] = t1 + t2;
    end

endmodule

FILE: sim/sha256_digest_checker.sv
`timescale 1ns / 1ps
// digest checker for the sha-256 byte stream hasher: watches both stream channels,
// predicts every digest word and compares; depends on shbh_pkg for word_t, used by tb

module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        shbh_pkg::word_t word;
        logic [2:0]      index;
        logic            last;
    } digest_beat_t;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_FIELD_AT = 56;
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam shbh_pkg::word_t ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam shbh_pkg::word_t START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [7:0]      msg_block [BLOCK_BYTES];
    int              fill;
    logic [63:0]     bit_total;
    shbh_pkg::word_t chain [8];
    digest_beat_t    expected_words [$];
    digest_beat_t    oldest;

    function automatic shbh_pkg::word_t rotr(input shbh_pkg::word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic run_rounds();
        shbh_pkg::word_t w [16];
        shbh_pkg::word_t v [8];
        shbh_pkg::word_t wt;
        shbh_pkg::word_t s0;
        shbh_pkg::word_t s1;
        shbh_pkg::word_t t1;
        shbh_pkg::word_t t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = chain[i];
        end
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                wt = w[r];
            end
            else
            begin
                s0 = rotr(w[(r-15) & 15], 7) ^ rotr(w[(r-15) & 15], 18) ^ (w[(r-15) & 15] >> 3);
                s1 = rotr(w[(r-2) & 15], 17) ^ rotr(w[(r-2) & 15], 19) ^ (w[(r-2) & 15] >> 10);
                wt = s1 + w[(r-7) & 15] + s0 + w[r & 15];
                w[r & 15] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            chain[i] = chain[i] + v[i];
        end
    endtask

    task automatic restart_message();
        fill = 0;
        bit_total = '0;
        for (int i = 0; i < 8; i++)
        begin
            chain[i] = START_HASH[i];
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        msg_block[fill] = b;
        fill++;
        bit_total = bit_total + 64'd8;
        if (fill == BLOCK_BYTES)
        begin
            run_rounds();
            fill = 0;
        end
    endtask

    task automatic close_message();
        int i;
        digest_beat_t beat;
        i = fill;
        msg_block[i] = PAD_MARK;
        i++;
        // no room left for the length field: zero fill and take an extra block
        if (i > LEN_FIELD_AT)
        begin
            while (i < BLOCK_BYTES)
            begin
                msg_block[i] = 8'h00;
                i++;
            end
            run_rounds();
            i = 0;
        end
        while (i < LEN_FIELD_AT)
        begin
            msg_block[i] = 8'h00;
            i++;
        end
        for (int k = 0; k < 8; k++)
        begin
            msg_block[LEN_FIELD_AT + k] = bit_total[63 - 8*k -: 8];
        end
        run_rounds();
        for (int k = 0; k < 8; k++)
        begin
            beat.word = chain[k];
            beat.index = 3'(k);
            beat.last = (k == 7);
            expected_words.push_back(beat);
        end
        restart_message();
    endtask

    task automatic report_mismatch(input string what, input shbh_pkg::word_t got,
                                   input shbh_pkg::word_t want);
        $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            expected_words.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected digest transaction", m_tdata[31:0], '0);
                end
                else
                begin
                    oldest = expected_words.pop_front();
                    if (m_tdata[31:0] !== oldest.word)
                    begin
                        report_mismatch("digest word", m_tdata[31:0], oldest.word);
                    end
                    if (m_tdata[34:32] !== oldest.index)
                    begin
                        report_mismatch("word index", 32'(m_tdata[34:32]), 32'(oldest.index));
                    end
                    if (m_tlast !== oldest.last)
                    begin
                        report_mismatch("last word flag", 32'(m_tlast), 32'(oldest.last));
                    end
                    if (m_tdata[39:35] !== 5'd0)
                    begin
                        report_mismatch("tdata fill bits", 32'(m_tdata[39:35]), '0);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                begin
                    absorb_byte(s_tdata);
                end
                if (s_tlast)
                begin
                    close_message();
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// top of the testbench for sha256_byte_stream_hasher_top: clock, reset, byte stream
// stimulus, output back-pressure and verdict; depends on shbh_pkg and sha256_digest_checker

module tb;

    localparam int ITEM_TARGET = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 300;
    localparam int EDGE_LENGTHS [6] = '{55, 56, 57, 63, 64, 65};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int          fail_count;
    int          pending;
    int          items_sent = 0;
    int          burst_left = 0;
    int          stall_cycles = 0;
    logic [9:0]  rx_phase = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sha256_byte_stream_hasher_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sha256_digest_checker digest_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver back-pressure: free running, random, sparse, then long stalls
    always @(negedge clk)
    begin
        rx_phase <= rx_phase + 10'd1;
        case (rx_phase[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= (rx_phase[1:0] == 2'd0);
            default: m_tready <= (rx_phase[4:0] < 5'd12);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sha256_byte_stream_hasher_top test failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic [7:0] b, input logic has_byte, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= has_byte;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (has_byte || last)
        begin
            items_sent++;
        end
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_message(input int len);
        logic byte_on_last;
        byte_on_last = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(8'($urandom_range(0, 255)), 1'b1, byte_on_last && (i == len - 1));
        end
        if (!byte_on_last)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        int len;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty messages, bare transactions, a byte on the last transaction, abc
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        settle();

        for (int m = 0; items_sent < ITEM_TARGET; m++)
        begin
            if (m == 0)
            begin
                len = EDGE_LENGTHS[$urandom_range(0, 5)];
            end
            else
            begin
                len = $urandom_range(0, 16);
            end
            send_message(len);
            if ($urandom_range(0, 3) == 0)
            begin
                settle();
            end
        end

        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("sha256_byte_stream_hasher_top test passed");
        end
        else
        begin
            $display("sha256_byte_stream_hasher_top test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/shbh_pkg.sv
design/shbh_round.sv
design/sha256_byte_stream_hasher_top.sv
sim/sha256_digest_checker.sv
sim/tb.sv
